FILE: rtl/olief_pkg.sv
`default_nettype none

package olief_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int OP_W     = 3;
    localparam int POS_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int FOUND_W  = 7;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam logic [FOUND_W-1:0] FOUND_NONE = {FOUND_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_INSERT     = 3'd0,
        OP_ERASE      = 3'd1,
        OP_FIND       = 3'd2,
        OP_CLEAR      = 3'd3,
        OP_PUSH_FRONT = 3'd4,
        OP_PUSH_BACK  = 3'd5,
        OP_POP_FRONT  = 3'd6,
        OP_POP_BACK   = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_FROM_LEFT  = 2'd2,
        CELL_FROM_RIGHT = 2'd3
    } cell_sel_t;

    typedef struct packed {
        cell_sel_t sel;
        logic      cmp_en;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/olief_cell.sv
`default_nettype none

module olief_cell
    import olief_pkg::*;
(
    input  wire logic               aclk,
    input  wire cell_ctrl_t         ctrl,
    input  wire logic [VALUE_W-1:0] left_value,
    input  wire logic [VALUE_W-1:0] right_value,
    input  wire logic [VALUE_W-1:0] load_value,
    input  wire logic [VALUE_W-1:0] key,
    output logic      [VALUE_W-1:0] value,
    output logic                    match
);

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;

    always_comb begin
        unique case (ctrl.sel)
            CELL_LOAD:       value_next = load_value;
            CELL_FROM_LEFT:  value_next = left_value;
            CELL_FROM_RIGHT: value_next = right_value;
            default:         value_next = value_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign match = ctrl.cmp_en && (value_reg == key);

endmodule

`default_nettype wire

FILE: rtl/olief_first_match.sv
`default_nettype none

module olief_first_match
    import olief_pkg::*;
(
    input  wire logic [CAPACITY-1:0] match,
    output logic                     hit,
    output logic      [IDX_W-1:0]    idx
);

    always_comb begin
        hit = 1'b0;
        idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit = 1'b1;
                idx = IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ordered_list_insert_erase_find.sv
// Ordered list of signed 32-bit values held in a row of cells, one entry per
// cell, index 0 at the front.
// Input channel s_*: one item carries an operation, a position and a value.
// Result channel m_*: exactly one item per input item, in order, carrying the
// first matching index (or -1), the entry count after the operation and a
// status (done, ignored, or rejected because full).
// Every cell loads, holds or takes its left or right neighbour in the cycle
// an item is accepted, so insert, erase, push and pop all complete in that
// cycle. Every occupied cell compares its entry with the search value in
// that cycle too; the match flags are registered and priority-encoded in a
// second stage. The result is offered from the result register after the
// item has passed the match stage; one item is accepted every cycle unless
// the receiver stalls.
// If the receiver stalls, the result and the stage before it hold; s_ready
// falls only when both are full, and resumes as soon as m_ready is high.
// Reset empties the list and drops any items in flight; stored values are
// not cleared, as entries past the count are never read.
`default_nettype none

module ordered_list_insert_erase_find
    import olief_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic        [OP_W-1:0]     s_operation,
    input  wire logic signed [POS_W-1:0]    s_position,
    input  wire logic signed [VALUE_W-1:0]  s_value,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed      [FOUND_W-1:0]  m_found_index,
    output logic             [COUNT_W-1:0]  m_entry_count,
    output logic             [STATUS_W-1:0] m_status
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic                a_valid_reg;
    logic [CAPACITY-1:0] a_match_reg;
    logic                a_find_reg;
    logic [CNT_W-1:0]    a_count_reg;
    status_t             a_status_reg;

    logic                m_valid_reg;
    logic [FOUND_W-1:0]  m_found_reg;
    logic [COUNT_W-1:0]  m_count_reg;
    status_t             m_status_reg;

    logic s_fire;
    logic a_advance;
    logic b_free;

    logic             do_ins;
    logic             do_del;
    logic             is_find;
    logic [CNT_W-1:0] tgt;
    status_t          status;

    logic                 pos_neg;
    logic [POS_W-2:0]     pos_u;
    logic [POS_W-2:0]     cnt_u;
    logic                 full;
    logic                 empty;

    cell_ctrl_t          ctrl       [CAPACITY];
    logic [VALUE_W-1:0]  cell_value [CAPACITY];
    logic [CAPACITY-1:0] match;

    logic             hit;
    logic [IDX_W-1:0] hit_idx;

    assign b_free    = !m_valid_reg || m_ready;
    assign a_advance = a_valid_reg && b_free;
    assign s_ready   = !a_valid_reg || b_free;
    assign s_fire    = s_valid && s_ready;

    assign pos_neg = s_position[POS_W-1];
    assign pos_u   = s_position[POS_W-2:0];
    assign cnt_u   = (POS_W - 1)'(count_reg);
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);

    always_comb begin
        do_ins     = 1'b0;
        do_del     = 1'b0;
        is_find    = 1'b0;
        tgt        = '0;
        status     = ST_DONE;
        count_next = count_reg;
        unique case (op_t'(s_operation))
            OP_INSERT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    do_ins     = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (pos_neg) begin
                        tgt = '0;
                    end else if (pos_u >= cnt_u) begin
                        tgt = count_reg;
                    end else begin
                        tgt = CNT_W'(pos_u);
                    end
                end
            end
            OP_ERASE: begin
                if (pos_neg || (pos_u >= cnt_u)) begin
                    status = ST_IGNORED;
                end else begin
                    do_del     = 1'b1;
                    tgt        = CNT_W'(pos_u);
                    count_next = count_reg - 1'b1;
                end
            end
            OP_FIND: begin
                is_find = 1'b1;
            end
            OP_CLEAR: begin
                count_next = '0;
            end
            OP_PUSH_FRONT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    do_ins     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_PUSH_BACK: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    do_ins     = 1'b1;
                    tgt        = count_reg;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    status = ST_IGNORED;
                end else begin
                    do_del     = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    status = ST_IGNORED;
                end else begin
                    do_del     = 1'b1;
                    tgt        = count_reg - 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);

        always_comb begin
            ctrl[i].cmp_en = (IDX < count_reg);
            ctrl[i].sel    = CELL_HOLD;
            if (s_fire && do_ins) begin
                if (IDX == tgt) begin
                    ctrl[i].sel = CELL_LOAD;
                end else if (IDX > tgt) begin
                    ctrl[i].sel = CELL_FROM_LEFT;
                end
            end else if (s_fire && do_del) begin
                if (IDX >= tgt) begin
                    ctrl[i].sel = CELL_FROM_RIGHT;
                end
            end
        end

        olief_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl[i]),
            .left_value  ((i == 0) ? s_value : cell_value[(i == 0) ? 0 : i - 1]),
            .right_value (cell_value[(i == CAPACITY - 1) ? i : i + 1]),
            .load_value  (s_value),
            .key         (s_value),
            .value       (cell_value[i]),
            .match       (match[i])
        );
    end

    olief_first_match u_first_match (
        .match (a_match_reg),
        .hit   (hit),
        .idx   (hit_idx)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                count_reg <= count_next;
            end
            if (s_fire) begin
                a_valid_reg <= 1'b1;
            end else if (a_advance) begin
                a_valid_reg <= 1'b0;
            end
            if (a_advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_match_reg  <= match;
            a_find_reg   <= is_find;
            a_count_reg  <= count_next;
            a_status_reg <= status;
        end
        if (a_advance) begin
            m_found_reg  <= (a_find_reg && hit) ? FOUND_W'(hit_idx) : FOUND_NONE;
            m_count_reg  <= COUNT_W'(a_count_reg);
            m_status_reg <= a_status_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_found_index = m_found_reg;
    assign m_entry_count = m_count_reg;
    assign m_status      = m_status_reg;

endmodule

`default_nettype wire

FILE: tb/tb_ordered_list_insert_erase_find.sv
`timescale 1ns / 1ps

module tb_ordered_list_insert_erase_find;
    import olief_pkg::*;

    localparam int HOLD_CYCLES = 150;
    localparam int STALL_LIMIT = 2000;
    localparam int PRINT_LIMIT = 30;

    typedef struct packed {
        logic [FOUND_W-1:0] found;
        logic [COUNT_W-1:0] count;
        status_t            status;
    } list_result_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic        [OP_W-1:0]      s_operation;
    logic signed [POS_W-1:0]     s_position;
    logic signed [VALUE_W-1:0]   s_value;
    logic                        m_valid;
    logic                        m_ready;
    logic signed [FOUND_W-1:0]   m_found_index;
    logic        [COUNT_W-1:0]   m_entry_count;
    logic        [STATUS_W-1:0]  m_status;

    logic [VALUE_W-1:0] model_entries[$];
    list_result_t       pending_results[$];

    int err_count     = 0;
    int send_idle_pct = 33;
    int recv_idle_pct = 59;
    int hold_start    = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    ordered_list_insert_erase_find dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_position    (s_position),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found_index (m_found_index),
        .m_entry_count (m_entry_count),
        .m_status      (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic list_result_t apply_list_op(op_t op, logic signed [POS_W-1:0] pos,
                                                   logic [VALUE_W-1:0] val);
        list_result_t r;
        int p;
        int n;
        r.found  = FOUND_NONE;
        r.status = ST_DONE;
        p = pos;
        n = model_entries.size();
        case (op)
            OP_INSERT, OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (n >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    if (op == OP_PUSH_FRONT || p < 0)
                        p = 0;
                    if (op == OP_PUSH_BACK || p > n)
                        p = n;
                    model_entries.insert(p, val);
                end
            end
            OP_ERASE, OP_POP_FRONT, OP_POP_BACK: begin
                if (op == OP_POP_FRONT)
                    p = 0;
                else if (op == OP_POP_BACK)
                    p = n - 1;
                if (p < 0 || p >= n)
                    r.status = ST_IGNORED;
                else
                    model_entries.delete(p);
            end
            OP_FIND: begin
                for (int i = 0; i < n; i++) begin
                    if (model_entries[i] == val) begin
                        r.found = FOUND_W'(i);
                        break;
                    end
                end
            end
            default: begin
                model_entries.delete();
            end
        endcase
        r.count = COUNT_W'(model_entries.size());
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return VALUE_W'($urandom_range(3));
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic signed [POS_W-1:0] pick_position(int hi);
        if ($urandom_range(4) == 0)
            return POS_W'($urandom_range(255));
        return POS_W'($urandom_range(hi, 0));
    endfunction

    task automatic report_error(string msg);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic send_list_op(op_t op, logic signed [POS_W-1:0] pos, logic [VALUE_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_position  <= pos;
        s_value     <= val;
        do
            @(posedge aclk);
        while (!s_ready);
        pending_results.insert(pending_results.size(), apply_list_op(op, pos, val));
    endtask

    // The receiver stalls at random, and for a long stretch whenever a hold is requested.
    always @(posedge aclk) begin
        if (hold_seen != hold_start) begin
            hold_seen = hold_start;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_error("result item with no item outstanding");
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (m_found_index !== want.found)
                    report_error($sformatf("found_index: got %0d, expected %0d",
                                           m_found_index, $signed(want.found)));
                if (m_entry_count !== want.count)
                    report_error($sformatf("entry_count: got %0d, expected %0d",
                                           m_entry_count, want.count));
                if (m_status !== want.status)
                    report_error($sformatf("status: got %0d, expected %0d",
                                           m_status, want.status));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_ordered_list_insert_erase_find: errors");
            $finish;
        end
    end

    task automatic test_empty_and_edges();
        send_list_op(OP_POP_FRONT, 8'sd0, 32'h0);
        send_list_op(OP_POP_BACK, 8'sd0, 32'h0);
        send_list_op(OP_ERASE, 8'sd0, 32'h0);
        send_list_op(OP_FIND, 8'sd0, 32'h0);
        send_list_op(OP_INSERT, 8'sh80, 32'h8000_0000);
        send_list_op(OP_INSERT, 8'sh7F, 32'h7FFF_FFFF);
        send_list_op(OP_INSERT, 8'sd1, 32'hFFFF_FFFF);
        send_list_op(OP_PUSH_FRONT, 8'sd0, 32'h0);
        send_list_op(OP_PUSH_BACK, 8'sd0, 32'hFFFF_FFFF);
        send_list_op(OP_FIND, 8'sd0, 32'hFFFF_FFFF);
        send_list_op(OP_FIND, 8'sd0, 32'h7FFF_FFFF);
        send_list_op(OP_FIND, 8'sd0, 32'h1234_5678);
        send_list_op(OP_INSERT, 8'sd0, 32'h5555_5555);
        send_list_op(OP_ERASE, -8'sd1, 32'h0);
        send_list_op(OP_ERASE, 8'sh7F, 32'h0);
        send_list_op(OP_ERASE, 8'sd6, 32'h0);
        send_list_op(OP_ERASE, 8'sd5, 32'h0);
        send_list_op(OP_ERASE, 8'sd2, 32'h0);
        send_list_op(OP_POP_FRONT, 8'sd0, 32'h0);
        send_list_op(OP_POP_BACK, 8'sd0, 32'h0);
        send_list_op(OP_CLEAR, 8'sd0, 32'h0);
        send_list_op(OP_FIND, 8'sd0, 32'h0);
        send_list_op(OP_INSERT, 8'sd3, 32'hAAAA_AAAA);
    endtask

    // Stretches that favour adding alternate with stretches that favour removing, so the
    // list runs between empty and full.
    task automatic test_random_mix(int n_items);
        op_t                     op;
        logic signed [POS_W-1:0] pos;
        logic [VALUE_W-1:0]      val;
        int                      n;
        int                      roll;
        bit                      grow;
        for (int i = 0; i < n_items; i++) begin
            n    = model_entries.size();
            grow = ((i / 40) % 2) == 0;
            roll = $urandom_range(99);
            pos  = POS_W'($urandom_range(255));
            val  = pick_value();
            if (roll < 15) begin
                op = OP_FIND;
                if (n != 0 && $urandom_range(9) < 6)
                    val = model_entries[$urandom_range(n - 1)];
            end else if (roll == 15) begin
                op = OP_CLEAR;
            end else if (roll < (grow ? 80 : 40)) begin
                case ($urandom_range(2))
                    0: begin
                        op  = OP_INSERT;
                        pos = pick_position(n + 1);
                    end
                    1: op = OP_PUSH_FRONT;
                    default: op = OP_PUSH_BACK;
                endcase
            end else begin
                case ($urandom_range(2))
                    0: begin
                        op  = OP_ERASE;
                        pos = pick_position(n);
                    end
                    1: op = OP_POP_FRONT;
                    default: op = OP_POP_BACK;
                endcase
            end
            send_list_op(op, pos, val);
        end
    endtask

    // The receiver holds off while the list is filled, so the block backs up and stalls
    // its input; the list is then full for the last adds.
    task automatic test_full_list_backpressure();
        hold_start <= hold_start + 1;
        send_list_op(OP_CLEAR, 8'sd0, 32'h0);
        for (int i = 0; i < CAPACITY; i++)
            send_list_op(OP_PUSH_BACK, POS_W'($urandom_range(255)), pick_value());
        send_list_op(OP_INSERT, pick_position(CAPACITY), $urandom());
        send_list_op(OP_PUSH_FRONT, 8'sd0, $urandom());
        send_list_op(OP_PUSH_BACK, 8'sd0, $urandom());
        send_list_op(OP_FIND, 8'sd0, model_entries[$urandom_range(CAPACITY - 1)]);
        send_list_op(OP_POP_BACK, 8'sd0, 32'h0);
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_operation = '0;
        s_position  = '0;
        s_value     = '0;
        m_ready     = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_and_edges();
        test_random_mix(220);

        send_idle_pct = 59;
        recv_idle_pct = 33;
        test_random_mix(220);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_full_list_backpressure();
        test_random_mix(165);

        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (err_count == 0)
            $display("tb_ordered_list_insert_erase_find: clean");
        else
            $display("tb_ordered_list_insert_erase_find: errors");
        $finish;
    end

endmodule
